FILE: src/hbls_pkg.sv
// Shared types, constants and control program of the heartbeat LED sequencer.
`timescale 1ns / 1ps

package hbls_pkg;

    localparam int LED_COUNT_DEF       = 8;
    localparam int SENSOR_COUNT_DEF    = 4;
    localparam int SYSTOLE_DIVISOR_DEF = 3;
    localparam int RATE_LIMIT_DEF      = 300;

    localparam int NOW_W      = 32;
    localparam int FLAGS_W    = 4;
    localparam int PATTERN_W  = 8;
    localparam int RATE_W     = 9;
    localparam int RAMP_W     = 6;
    localparam int INTERVAL_W = 16;
    localparam int INDEX_W    = 4;
    localparam int CYCLE_W    = 16;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PC_W       = 4;
    localparam int DIV_CNT_W  = $clog2(CYCLE_W + 1);

    localparam logic [CYCLE_W-1:0]    MS_PER_MINUTE    = 16'd60000;
    localparam logic [RATE_W-1:0]     RESET_MIN_RATE   = 9'd60;
    localparam logic [RATE_W-1:0]     RESET_MAX_RATE   = 9'd120;
    localparam logic [RAMP_W-1:0]     RESET_RAMP       = 6'd5;
    localparam logic [INTERVAL_W-1:0] RESET_INTERVAL   = 16'd250;
    localparam logic [STEP_W-1:0]     RESET_STEP_MS    = 16'd42;
    localparam logic [CYCLE_W-1:0]    RESET_CYCLE_MS   = 16'd1000;
    localparam logic [RATE_W-1:0]     RESET_RATE       = 9'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_RATE,
        CFG_MAX_RATE,
        CFG_RAMP_STEP,
        CFG_CHECK_INTERVAL
    } t_cfg_reg;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_LED,
        OP_DIV_RATE,
        OP_STORE_CYCLE,
        OP_SPIN,
        OP_STORE_STEP,
        OP_CHECK,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_REQ,
        JC_NO_RECALC,
        JC_DIV_WAIT,
        JC_OUT_BLOCKED
    } t_jcond;

    typedef struct packed {
        t_op              op;
        t_jcond           cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Control program: fall through to pc+1 unless the jump condition holds.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{OP_WAIT,        JC_NO_REQ,      4'd0};
            4'd1:    w = '{OP_LED,         JC_NO_RECALC,   4'd6};
            4'd2:    w = '{OP_DIV_RATE,    JC_NEVER,       4'd0};
            4'd3:    w = '{OP_SPIN,        JC_DIV_WAIT,    4'd3};
            4'd4:    w = '{OP_STORE_CYCLE, JC_NEVER,       4'd0};
            4'd5:    w = '{OP_STORE_STEP,  JC_NEVER,       4'd0};
            4'd6:    w = '{OP_CHECK,       JC_OUT_BLOCKED, 4'd6};
            4'd7:    w = '{OP_NOP,         JC_ALWAYS,      4'd0};
            default: w = '{OP_NOP,         JC_ALWAYS,      4'd0};
        endcase
        return w;
    endfunction

endpackage

FILE: src/hbls_divider.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hbls_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [hbls_pkg::CYCLE_W-1:0]     i_dividend,
    input  logic [hbls_pkg::RATE_W-1:0]      i_divisor,
    output hbls_pkg::t_div_stat              o_stat,
    output logic [hbls_pkg::CYCLE_W-1:0]     o_quotient
);
    import hbls_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_count, n_count;
    logic [RATE_W-1:0]     r_rem, n_rem;
    logic [RATE_W-1:0]     r_dvsr, n_dvsr;
    logic [CYCLE_W-1:0]    r_quo, n_quo;

    logic [RATE_W:0]       w_rem_sh;
    logic [RATE_W:0]       w_diff;
    logic                  w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[CYCLE_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dvsr});
        w_diff   = w_rem_sh - {1'b0, r_dvsr};

        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_rem   = r_rem;
        n_dvsr  = r_dvsr;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = '0;
            n_rem   = '0;
            n_dvsr  = i_divisor;
            n_quo   = i_dividend;
        end else if (r_busy) begin
            // keep the partial remainder below the divisor
            n_rem   = w_ge ? w_diff[RATE_W-1:0] : w_rem_sh[RATE_W-1:0];
            n_quo   = {r_quo[CYCLE_W-2:0], w_ge};
            n_count = r_count + 1'b1;
            if (r_count == DIV_CNT_W'(CYCLE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_rem  <= n_rem;
        r_dvsr <= n_dvsr;
        r_quo  <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

FILE: src/heartbeat_led_sequencer_core.sv
// Top level of the heartbeat LED sequencer: control program, datapath and ports.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid / o_stall): one request per update, carrying the
//   millisecond time and the sensor lines, taken at a clock edge with i_valid
//   high and o_stall low. o_stall is low only while the program waits.
//   Output channel (o_valid / i_stall): exactly one result per request, held
//   in an output register until the receiver drops i_stall.
//   Configuration (i_cfg_valid / o_cfg_ready): ready is always high; write
//   the four registers only while no request is in flight.
// Sequence
//   Without a rate change a request runs through the LED update and the rate
//   check, which loads the result register and raises o_valid; the program
//   then returns to the wait step, the only step that takes a request. A beat
//   start that adopts a new rate inserts the serial division 60000 / rate,
//   then stores the beat length and then the rounded step by reciprocal
//   multiply, all before the rate check.
// Reset: synchronous, active low; systole, 60 bpm, 1000 ms beat, 42 ms step,
//   configuration back to its defaults.
// Stall: a waiting result holds the program at the rate check step; one more
//   request may be taken and run up to that step meanwhile.

module heartbeat_led_sequencer_core #(
    parameter int LED_COUNT       = hbls_pkg::LED_COUNT_DEF,
    parameter int SENSOR_COUNT    = hbls_pkg::SENSOR_COUNT_DEF,
    parameter int SYSTOLE_DIVISOR = hbls_pkg::SYSTOLE_DIVISOR_DEF,
    parameter int RATE_LIMIT_BPM  = hbls_pkg::RATE_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hbls_pkg::NOW_W-1:0]          i_now_ms,
    input  logic [hbls_pkg::FLAGS_W-1:0]        i_sensor_flags,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hbls_pkg::PATTERN_W-1:0]      o_led_pattern,
    output logic                                o_led_written,
    output logic                                o_beat_started,
    output logic [hbls_pkg::RATE_W-1:0]         o_rate_bpm,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hbls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hbls_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hbls_pkg::*;

    localparam int DIV_TOTAL = LED_COUNT * SYSTOLE_DIVISOR;
    localparam logic [CYCLE_W-1:0] DIV_HALF  = CYCLE_W'(DIV_TOTAL / 2);
    localparam logic [RATE_W-1:0]  LIMIT     = RATE_W'(RATE_LIMIT_BPM);
    localparam logic [INDEX_W-1:0] LED_LAST  = INDEX_W'(LED_COUNT);
    localparam logic [FLAGS_W-1:0] SENSOR_MASK = (SENSOR_COUNT >= FLAGS_W) ?
        {FLAGS_W{1'b1}} : FLAGS_W'((1 << SENSOR_COUNT) - 1);
    localparam int PROD_W = STEP_W + INDEX_W;

    // step = (cycle + half) / DIV_TOTAL by reciprocal multiply, exact for 16-bit operands
    localparam int     STEP_SHIFT   = CYCLE_W + $clog2(DIV_TOTAL);
    localparam int     RECIP_W      = CYCLE_W + 1;
    localparam longint STEP_RECIP_L = ((longint'(1) << STEP_SHIFT) +
                                       longint'(DIV_TOTAL) - 1) / longint'(DIV_TOTAL);
    localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'(STEP_RECIP_L);
    localparam int     STEP_PROD_W  = CYCLE_W + RECIP_W;

    // program counter and captured request
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [NOW_W-1:0]      r_now;
    logic [FLAGS_W-1:0]    r_flags;

    // configuration
    logic [RATE_W-1:0]     r_min, r_max;
    logic [RAMP_W-1:0]     r_ramp;
    logic [INTERVAL_W-1:0] r_interval;

    // beat state
    logic                  r_diastole, n_diastole;
    logic [INDEX_W-1:0]    r_index, n_index;
    logic [NOW_W-1:0]      r_cycle_start, n_cycle_start;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [CYCLE_W-1:0]    r_cycle, n_cycle;
    logic [RATE_W-1:0]     r_active, n_active;
    logic [RATE_W-1:0]     r_pending, n_pending;
    logic [RATE_W-1:0]     r_target, n_target;
    logic [NOW_W-1:0]      r_last_check, n_last_check;
    logic [PATTERN_W-1:0]  r_shown, n_shown;
    logic                  r_written, n_written;
    logic                  r_began, n_began;

    // result register
    logic                  r_out_valid, n_out_valid;
    logic [PATTERN_W-1:0]  r_out_pattern;
    logic                  r_out_written;
    logic                  r_out_began;
    logic [RATE_W-1:0]     r_out_rate;

    t_uword                w_uw;
    logic                  w_accept;
    logic                  w_out_blocked;
    logic                  w_recalc;
    logic                  w_jump;
    logic                  w_check_go;
    logic [PROD_W-1:0]     w_prod;
    logic [NOW_W-1:0]      w_due_led;
    logic [NOW_W-1:0]      w_due_beat;
    logic [RATE_W:0]       w_up;
    logic [RATE_W:0]       w_dn;
    logic [RATE_W-1:0]     w_ramped;
    logic                  w_run_check;
    logic [NOW_W-1:0]      w_elapsed;
    logic [CYCLE_W-1:0]    w_step_num;
    logic [STEP_PROD_W-1:0] w_step_prod;

    logic                  w_div_start;
    logic [CYCLE_W-1:0]    w_div_dividend;
    logic [RATE_W-1:0]     w_div_divisor;
    t_div_stat             w_div_stat;
    logic [CYCLE_W-1:0]    w_div_quo;

    hbls_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quo)
    );

    assign w_uw          = ucode(r_pc);
    assign o_stall       = (w_uw.op != OP_WAIT);
    assign w_accept      = i_valid && !o_stall;
    assign w_out_blocked = r_out_valid && i_stall;
    assign w_check_go    = (w_uw.op == OP_CHECK) && !w_out_blocked;

    // deadlines wrap modulo 2^32
    assign w_prod     = r_step * r_index;
    assign w_due_led  = r_cycle_start + {{(NOW_W - PROD_W){1'b0}}, w_prod};
    assign w_due_beat = r_cycle_start + {{(NOW_W - CYCLE_W){1'b0}}, r_cycle};

    // ramp the target, clamp to the configured bounds
    assign w_up = {1'b0, r_target} + {{(RATE_W + 1 - RAMP_W){1'b0}}, r_ramp};
    assign w_dn = {1'b0, r_target} - {{(RATE_W + 1 - RAMP_W){1'b0}}, r_ramp};
    always_comb begin
        if ((r_flags & SENSOR_MASK) != '0) begin
            w_ramped = (w_up > {1'b0, r_max}) ? r_max : w_up[RATE_W-1:0];
        end else begin
            w_ramped = (w_dn[RATE_W] || (w_dn[RATE_W-1:0] < r_min)) ?
                       r_min : w_dn[RATE_W-1:0];
        end
    end
    assign w_elapsed = r_now - r_last_check;

    // divider computes the beat length; the rounded LED step follows from it
    assign w_div_start    = (w_uw.op == OP_DIV_RATE);
    assign w_div_dividend = MS_PER_MINUTE;
    assign w_div_divisor  = (r_active == '0) ? RATE_W'(1) : r_active;
    assign w_step_num     = r_cycle + DIV_HALF;
    assign w_step_prod    = w_step_num * STEP_RECIP;

    always_comb begin
        n_diastole    = r_diastole;
        n_index       = r_index;
        n_cycle_start = r_cycle_start;
        n_step        = r_step;
        n_cycle       = r_cycle;
        n_active      = r_active;
        n_pending     = r_pending;
        n_target      = r_target;
        n_last_check  = r_last_check;
        n_shown       = r_shown;
        n_written     = r_written;
        n_began       = r_began;
        w_recalc      = 1'b0;
        w_run_check   = 1'b0;

        case (w_uw.op)
            OP_LED: begin
                n_written = 1'b0;
                n_began   = 1'b0;
                if (!r_diastole) begin
                    if (r_index >= LED_LAST) begin
                        // last LED passed: enter diastole, write nothing
                        n_diastole = 1'b1;
                    end else if (r_now >= w_due_led) begin
                        n_shown   = PATTERN_W'(1) << r_index[2:0];
                        n_written = 1'b1;
                        n_index   = r_index + 1'b1;
                    end
                end else if (r_now >= w_due_beat) begin
                    n_diastole    = 1'b0;
                    n_index       = '0;
                    n_cycle_start = r_now;
                    n_began       = 1'b1;
                    if (r_pending != r_active) begin
                        n_active = r_pending;
                        w_recalc = 1'b1;
                    end
                end
            end
            OP_STORE_CYCLE: begin
                n_cycle = w_div_quo;
            end
            OP_STORE_STEP: begin
                n_step = STEP_W'(w_step_prod >> STEP_SHIFT);
            end
            OP_CHECK: begin
                if (w_check_go) begin
                    if (r_interval == '0) begin
                        w_run_check = 1'b1;
                    end else if (r_last_check == '0) begin
                        // first check only arms the timer
                        n_last_check = r_now;
                    end else if (w_elapsed > {{(NOW_W - INTERVAL_W){1'b0}}, r_interval}) begin
                        n_last_check = r_now;
                        w_run_check  = 1'b1;
                    end
                    if (w_run_check) begin
                        n_target = w_ramped;
                        if ((w_ramped != r_active) && (w_ramped <= LIMIT) &&
                            (w_ramped != '0)) begin
                            n_pending = w_ramped;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // step counter: jump on the control word's condition, else advance
    always_comb begin
        case (w_uw.cond)
            JC_NEVER:       w_jump = 1'b0;
            JC_ALWAYS:      w_jump = 1'b1;
            JC_NO_REQ:      w_jump = !i_valid;
            JC_NO_RECALC:   w_jump = !w_recalc;
            JC_DIV_WAIT:    w_jump = !w_div_stat.done;
            JC_OUT_BLOCKED: w_jump = w_out_blocked;
            default:        w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + 1'b1;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_check_go) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= '0;
            r_min         <= RESET_MIN_RATE;
            r_max         <= RESET_MAX_RATE;
            r_ramp        <= RESET_RAMP;
            r_interval    <= RESET_INTERVAL;
            r_diastole    <= 1'b0;
            r_index       <= '0;
            r_cycle_start <= '0;
            r_step        <= RESET_STEP_MS;
            r_cycle       <= RESET_CYCLE_MS;
            r_active      <= RESET_RATE;
            r_pending     <= RESET_RATE;
            r_target      <= RESET_RATE;
            r_last_check  <= '0;
            r_shown       <= '0;
            r_written     <= 1'b0;
            r_began       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_pc          <= n_pc;
            r_diastole    <= n_diastole;
            r_index       <= n_index;
            r_cycle_start <= n_cycle_start;
            r_step        <= n_step;
            r_cycle       <= n_cycle;
            r_active      <= n_active;
            r_pending     <= n_pending;
            r_target      <= n_target;
            r_last_check  <= n_last_check;
            r_shown       <= n_shown;
            r_written     <= n_written;
            r_began       <= n_began;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_MIN_RATE:       r_min      <= i_cfg_data[RATE_W-1:0];
                    CFG_MAX_RATE:       r_max      <= i_cfg_data[RATE_W-1:0];
                    CFG_RAMP_STEP:      r_ramp     <= i_cfg_data[RAMP_W-1:0];
                    CFG_CHECK_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        // payload: capture on accept, load result on check
        if (w_accept) begin
            r_now   <= i_now_ms;
            r_flags <= i_sensor_flags;
        end
        if (w_check_go) begin
            r_out_pattern <= r_shown;
            r_out_written <= r_written;
            r_out_began   <= r_began;
            r_out_rate    <= n_target;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_led_pattern  = r_out_pattern;
    assign o_led_written  = r_out_written;
    assign o_beat_started = r_out_began;
    assign o_rate_bpm     = r_out_rate;

    // divider is only restarted once it has finished
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    // a written pattern lights exactly one LED
    a_written_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_led_written) |-> $onehot(o_led_pattern))
        else $error("written LED pattern not one-hot");

    // an update lights an LED or starts a beat, never both
    a_written_or_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_led_written && o_beat_started))
        else $error("LED write and beat start on one update");

    // pending rate stays within the usable range, the LED index within the LED count
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) && (r_pending <= LIMIT) && (r_index <= LED_LAST))
        else $error("pending rate or LED index out of range");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the heartbeat LED sequencer core.
`timescale 1ns / 1ps

module tb_top;

    import hbls_pkg::*;

    localparam int LED_DIV          = LED_COUNT_DEF * SYSTOLE_DIVISOR_DEF;
    localparam int SENSOR_MASK      = (1 << SENSOR_COUNT_DEF) - 1;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_PRINTED      = 40;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic                 written;
        logic                 began;
        logic [RATE_W-1:0]    rate;
    } t_led_update;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_PERIODIC
    } t_stall_mode;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic                  upd_valid  = 1'b0;
    logic                  upd_stall;
    logic [NOW_W-1:0]      upd_now_ms = '0;
    logic [FLAGS_W-1:0]    upd_flags  = '0;
    logic                  res_valid;
    logic                  res_stall  = 1'b0;
    logic [PATTERN_W-1:0]  res_pattern;
    logic                  res_written;
    logic                  res_beat;
    logic [RATE_W-1:0]     res_rate;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    t_cfg_reg              cfg_index  = CFG_MIN_RATE;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    heartbeat_led_sequencer_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (upd_valid),
        .o_stall        (upd_stall),
        .i_now_ms       (upd_now_ms),
        .i_sensor_flags (upd_flags),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_led_pattern  (res_pattern),
        .o_led_written  (res_written),
        .o_beat_started (res_beat),
        .o_rate_bpm     (res_rate),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer and its registers
    // ------------------------------------------------------------------
    int          cfg_min      = RESET_MIN_RATE;
    int          cfg_max      = RESET_MAX_RATE;
    int          cfg_ramp     = RESET_RAMP;
    int          cfg_interval = RESET_INTERVAL;

    bit          sim_diastole   = 1'b0;
    int          sim_led        = 0;
    logic [31:0] sim_beat_start = '0;
    logic [31:0] sim_step       = 32'(RESET_STEP_MS);
    logic [31:0] sim_period     = 32'(RESET_CYCLE_MS);
    logic [8:0]  sim_active     = RESET_RATE;
    logic [8:0]  sim_pending    = RESET_RATE;
    logic [8:0]  sim_target     = RESET_RATE;
    logic [31:0] sim_last_check = '0;
    logic [7:0]  sim_pattern    = '0;

    t_led_update awaited_updates[$];
    int          error_count   = 0;
    int          results_seen  = 0;
    int          hold_request  = 0;
    int          burst_left    = 0;
    bit          pace_gaps     = 1'b1;
    logic [31:0] clock_ms      = '0;

    // Advance the private sequencer by one update and return what the block must show.
    function automatic t_led_update predict_led_update(input logic [31:0] now,
                                                       input logic [3:0]  flags);
        t_led_update r;
        logic [31:0] due;
        logic [31:0] elapsed;
        bit          run_check;
        int          t;
        int          v;
        r.written = 1'b0;
        r.began   = 1'b0;
        run_check = 1'b0;

        if (!sim_diastole) begin
            if (sim_led >= LED_COUNT_DEF) begin
                // last LED already shown: only switch phase
                sim_diastole = 1'b1;
            end else begin
                due = sim_beat_start + sim_step * 32'(sim_led);
                if (now >= due) begin
                    sim_pattern = 8'd1 << sim_led;
                    r.written   = 1'b1;
                    sim_led++;
                end
            end
        end else begin
            due = sim_beat_start + sim_period;
            if (now >= due) begin
                sim_diastole = 1'b0;
                sim_led      = 0;
                if (sim_pending != sim_active) begin
                    sim_active = sim_pending;
                    sim_period = 32'd60000 / 32'(sim_active);
                    sim_step   = (sim_period + 32'(LED_DIV / 2)) / 32'(LED_DIV);
                end
                sim_beat_start = now;
                r.began        = 1'b1;
            end
        end

        // periodic sensor check; a stored time of zero means not yet armed
        if (cfg_interval == 0) begin
            run_check = 1'b1;
        end else if (sim_last_check == 32'd0) begin
            sim_last_check = now;
        end else begin
            elapsed = now - sim_last_check;
            if (elapsed > 32'(cfg_interval)) begin
                sim_last_check = now;
                run_check      = 1'b1;
            end
        end

        if (run_check) begin
            t = int'(sim_target);
            if ((int'(flags) & SENSOR_MASK) != 0) begin
                v = t + cfg_ramp;
                t = (v > cfg_max) ? cfg_max : v;
            end else begin
                v = t - cfg_ramp;
                t = (v < cfg_min) ? cfg_min : v;
            end
            sim_target = 9'(t);
            if (sim_target != sim_active && sim_target <= RATE_LIMIT_DEF && sim_target != 0)
                sim_pending = sim_target;
        end

        r.pattern = sim_pattern;
        r.rate    = sim_target;
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Request side: one request per call, with bursts and random gaps
    // ------------------------------------------------------------------
    task automatic send_update(input logic [31:0] now, input logic [3:0] flags);
        int gap;
        @(negedge clk);
        upd_valid  <= 1'b1;
        upd_now_ms <= now;
        upd_flags  <= flags;
        do @(posedge clk); while (upd_stall);
        awaited_updates.push_back(predict_led_update(now, flags));

        if (pace_gaps) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(5, 1);
                // drop valid and scramble the idle payload
                repeat (gap) begin
                    @(negedge clk);
                    upd_valid  <= 1'b0;
                    upd_now_ms <= $urandom;
                    upd_flags  <= 4'($urandom);
                end
                burst_left = $urandom_range(12, 1);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Drop valid and hold until every outstanding result has been checked.
    task automatic wait_for_results();
        @(negedge clk);
        upd_valid <= 1'b0;
        while (awaited_updates.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(value);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MIN_RATE:       cfg_min      = value & 'h1FF;
            CFG_MAX_RATE:       cfg_max      = value & 'h1FF;
            CFG_RAMP_STEP:      cfg_ramp     = value & 'h3F;
            CFG_CHECK_INTERVAL: cfg_interval = value & 'hFFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only with the block idle: drain, let the program return, write.
    task automatic set_config(input int min_bpm, input int max_bpm,
                              input int ramp, input int interval);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_MIN_RATE, min_bpm);
        write_reg(CFG_MAX_RATE, max_bpm);
        write_reg(CFG_RAMP_STEP, ramp);
        write_reg(CFG_CHECK_INTERVAL, interval);
    endtask

    // Move time forward at the pace of the current LED step so beats keep coming,
    // often landing exactly on the next deadline, with a few stale timestamps mixed in.
    task automatic walk_updates(input int count);
        logic [31:0] deadline;
        logic [31:0] now;
        logic [3:0]  flags;
        int          roll;
        int          sensor_pct;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                now = $urandom_range(clock_ms);
            end else begin
                if (sim_diastole)
                    deadline = sim_beat_start + sim_period;
                else if (sim_led < LED_COUNT_DEF)
                    deadline = sim_beat_start + sim_step * 32'(sim_led);
                else
                    deadline = clock_ms;
                if (roll < 30 && deadline > clock_ms)
                    clock_ms = deadline;
                else
                    clock_ms = clock_ms + $urandom_range(2 * sim_step + 2);
                now = clock_ms;
            end
            // alternate quiet and busy sensor stretches so the rate ramps both ways
            sensor_pct = ((i / 30) % 2 == 1) ? 85 : 10;
            flags = ($urandom_range(99) < sensor_pct) ? 4'($urandom_range(15, 1)) : 4'd0;
            send_update(now, flags);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern of its own, plus a long hold on request
    // ------------------------------------------------------------------
    initial begin : result_stall_gen
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                res_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(3));
                    mode_left = $urandom_range(120, 20);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  res_stall <= 1'b0;
                    STALL_HALF:  res_stall <= 1'($urandom_range(1));
                    STALL_LIGHT: res_stall <= ($urandom_range(4) == 0);
                    default:     res_stall <= (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_led_update want;
        if (rst_n && res_valid && !res_stall) begin
            results_seen++;
            if (awaited_updates.size() == 0) begin
                report_error($sformatf("result %0d with no request outstanding", results_seen));
            end else begin
                want = awaited_updates.pop_front();
                if (res_pattern !== want.pattern)
                    report_error($sformatf("result %0d led_pattern %02h, want %02h",
                                           results_seen, res_pattern, want.pattern));
                if (res_written !== want.written)
                    report_error($sformatf("result %0d led_written %b, want %b",
                                           results_seen, res_written, want.written));
                if (res_beat !== want.began)
                    report_error($sformatf("result %0d beat_started %b, want %b",
                                           results_seen, res_beat, want.began));
                if (res_rate !== want.rate)
                    report_error($sformatf("result %0d rate_bpm %0d, want %0d",
                                           results_seen, res_rate, want.rate));
            end
        end
    end

    // End the run when nothing at all is handed over for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((upd_valid && !upd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: one full beat by hand, unarmed check, time extremes.
    task automatic test_directed();
        send_update(32'd0, 4'h0);     // first LED due at once; check stays unarmed at zero
        send_update(32'd0, 4'hF);
        send_update(32'd41, 4'h0);    // just short of the second LED; arms the check
        send_update(32'd42, 4'h1);
        send_update(32'd300, 4'h8);   // check runs, target moves up
        repeat (5) send_update(32'd300, 4'h0);
        send_update(32'd300, 4'h0);   // past the last LED: enter diastole only
        send_update(32'd999, 4'h0);   // target falls back to the active rate
        send_update(32'd1000, 4'h2);  // beat start adopts the pending rate
        send_update(32'hFFFF_FFFF, 4'hF);
        send_update(32'h7FFF_FFFF, 4'h4);
        clock_ms = 32'h7FFF_FFFF;
        for (int b = 0; b < SENSOR_COUNT_DEF; b++) begin
            clock_ms = clock_ms + 32'd60;
            send_update(clock_ms, 4'(1 << b));
        end
        clock_ms = clock_ms + 32'd300;
        send_update(clock_ms, 4'hA);
        clock_ms = clock_ms + 32'd300;
        send_update(clock_ms, 4'h5);
    endtask

    task automatic test_default_walk();
        walk_updates(180);
    endtask

    // Widest legal bounds and the largest ramp: rates swing from 1 to 300 bpm.
    task automatic test_full_range();
        set_config(1, 300, 63, 100);
        walk_updates(200);
    endtask

    task automatic test_crossed_bounds();
        set_config(200, 100, 17, 300);
        walk_updates(120);
    endtask

    // Zero interval checks on every update; run this stretch without sender gaps.
    task automatic test_interval_zero();
        set_config(1, 300, 40, 0);
        pace_gaps = 1'b0;
        walk_updates(150);
        pace_gaps = 1'b1;
    endtask

    // Bounds beyond the legal window: targets of 0 and above the limit must not go pending.
    task automatic test_out_of_range_targets();
        set_config(0, 400, 63, 50);
        walk_updates(100);
    endtask

    // Deadlines and elapsed time cross the 32-bit wrap; ramp off, check rarely due.
    task automatic test_time_wrap();
        set_config(60, 120, 0, 65535);
        clock_ms = 32'hFFFF_FFFF - 32'd30000;
        walk_updates(120);
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        set_config(60, 120, 5, 250);
        pace_gaps    = 1'b0;
        hold_request = LONG_HOLD_CYCLES;
        walk_updates(40);
        wait_for_results();
        pace_gaps = 1'b1;
    endtask

    task automatic test_random_times();
        set_config($urandom_range(300, 1), $urandom_range(300, 1),
                   $urandom_range(63), $urandom_range(65535));
        repeat (100) send_update($urandom, 4'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_default_walk();
        test_full_range();
        test_crossed_bounds();
        test_interval_zero();
        test_out_of_range_targets();
        test_time_wrap();
        test_backpressure();
        test_random_times();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
src/hbls_pkg.sv
src/hbls_divider.sv
src/heartbeat_led_sequencer_core.sv
dv/tb_top.sv
